// ----- rtl/core/imheq_pkg.sv -----
// Package for the indexed min-heap event queue.
// Holds the request and result transaction types and the mode and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imheq_pkg;
	localparam int IdBits   = 10;
	localparam int TimeBits = 40;
	localparam int CountBits = 11;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_CHANGE = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_PRESENT = 2'd3;

	typedef struct packed {
		logic [1:0]          mode;
		logic [IdBits-1:0]   event_id;
		logic [TimeBits-1:0] fire_time;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [IdBits-1:0]    earliest_id;
		logic [TimeBits-1:0]  earliest_time;
		logic                 is_empty;
		logic [CountBits-1:0] entry_count;
	} rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/indexed_min_heap_event_queue_top.sv -----
// Indexed min-heap event queue, top level.
// Depends on imheq_pkg for transaction types and codes.
//
// Usage: drive req and raise start while busy is low; the transaction is
// taken at that edge and busy rises. The result appears on rsp for exactly
// one cycle with done high; the receiver cannot stall it. Busy stays high
// through that cycle, so the next request is taken at the end of the cycle
// after done at the earliest.
// The heap lives in one slot memory (id and time per slot) and a position
// memory (id to slot), both synchronous with a registered read port.
// Sequence: rejected items and undefined modes go from the position lookup
// straight to reading out the top. An accepted item first places the entry
// (add, change) or moves the last entry into the vacated slot (remove),
// then sifts up or down on a heap of up to 1024 entries, and then reads
// out the top. The sift walk is the long part: each level reads the
// parent or the children, then writes two slots and two positions
// through the single write port of each memory.
// After reset the position memory is cleared by a pass over all 1024
// entries, one entry a cycle, during which busy stays high. The slot memory
// is not cleared; only slots within the count are ever used.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_event_queue_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  imheq_pkg::req_t      req,
	output logic                 busy,
	output logic                 done,
	output imheq_pkg::rsp_t      rsp
);
	import imheq_pkg::*;

	localparam int Cap = 1024;
	localparam int PB  = CountBits;

	localparam logic [4:0] S_CLR = 5'd0,  S_IDLE = 5'd1,  S_POS = 5'd2,
		S_DEC = 5'd3, S_RLAST = 5'd4, S_RMW = 5'd5, S_SIFT = 5'd6,
		S_RCUR = 5'd7, S_RUP = 5'd8, S_CMPUP = 5'd9, S_RL = 5'd10,
		S_RR = 5'd11, S_CMPDN = 5'd12, S_SW2 = 5'd13, S_SWP = 5'd14,
		S_TOP = 5'd15, S_TOPW = 5'd16, S_OUT = 5'd17, S_RMW2 = 5'd18;

	logic [4:0] st_q;
	logic [PB-1:0] cnt_q;
	logic [1:0] status_q;
	req_t req_q;
	logic [IdBits-1:0] clr_q;

	// memories
	logic [IdBits+TimeBits-1:0] slot_mem [Cap];
	logic [PB-1:0] pos_mem [Cap];
	logic [IdBits+TimeBits-1:0] slot_rd;
	logic [PB-1:0] pos_rd;
	logic [IdBits-1:0] sl_ra, sl_wa, ps_ra, ps_wa;
	logic sl_we, ps_we;
	logic [IdBits+TimeBits-1:0] sl_wd;
	logic [PB-1:0] ps_wd;

	always_ff @(posedge clk) begin
		if (sl_we) slot_mem[sl_wa] <= sl_wd;
		slot_rd <= slot_mem[sl_ra];
	end
	always_ff @(posedge clk) begin
		if (ps_we) pos_mem[ps_wa] <= ps_wd;
		pos_rd <= pos_mem[ps_ra];
	end

	// sift working registers: slot positions are 1-based
	logic [PB-1:0] cur_q, oth_q, pos_q;
	logic [IdBits-1:0] cid_q, oid_q, lid_q;
	logic [TimeBits-1:0] ct_q, ot_q, lt_q;
	logic second_q;

	function automatic logic [IdBits-1:0] adr(input logic [PB-1:0] p);
		logic [PB-1:0] m;
		begin
			m = p - PB'(1);
			adr = m[IdBits-1:0];
		end
	endfunction

	wire [PB-1:0] up_w = cur_q >> 1;
	wire [PB:0] left_x = {cur_q, 1'b0};
	wire [PB-1:0] left_w = left_x[PB-1:0];
	wire [PB-1:0] right_w = left_w | PB'(1);
	wire has_left = left_x <= {1'b0, cnt_q};
	wire has_right = (left_x | (PB+1)'(1)) <= {1'b0, cnt_q};
	wire [IdBits-1:0] rd_id = slot_rd[IdBits+TimeBits-1:TimeBits];
	wire [TimeBits-1:0] rd_t = slot_rd[TimeBits-1:0];
	wire pos_ok = (pos_rd != '0) && (pos_rd <= cnt_q);

	// memory port control
	always_comb begin
		sl_ra = adr(cur_q); sl_we = 1'b0; sl_wa = adr(cur_q);
		sl_wd = {cid_q, ct_q};
		ps_ra = req_q.event_id; ps_we = 1'b0; ps_wa = cid_q; ps_wd = cur_q;
		case (st_q)
			S_CLR: begin
				ps_we = 1'b1; ps_wa = clr_q; ps_wd = '0;
			end
			S_IDLE: ps_ra = req.event_id;
			S_RLAST: sl_ra = adr(cnt_q);
			S_RMW: begin
				// place the added, changed or moved entry
				sl_we = 1'b1; sl_wa = adr(cur_q); sl_wd = {cid_q, ct_q};
				ps_we = 1'b1; ps_wa = cid_q; ps_wd = cur_q;
			end
			S_RMW2: begin
				// mark the removed id absent
				ps_we = 1'b1; ps_wa = req_q.event_id; ps_wd = '0;
			end
			S_RCUR: sl_ra = adr(cur_q);
			S_RUP: sl_ra = adr(up_w);
			S_RL: sl_ra = adr(left_w);
			S_RR: sl_ra = adr(right_w);
			S_SW2: begin
				sl_we = 1'b1; sl_wa = adr(cur_q); sl_wd = {oid_q, ot_q};
				ps_we = 1'b1; ps_wa = oid_q; ps_wd = cur_q;
			end
			S_SWP: begin
				sl_we = 1'b1; sl_wa = adr(oth_q); sl_wd = {cid_q, ct_q};
				ps_we = 1'b1; ps_wa = cid_q; ps_wd = oth_q;
			end
			S_TOP: sl_ra = '0;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; cnt_q <= '0; clr_q <= '0; status_q <= ST_OK;
		end else begin
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + IdBits'(1);
					if (clr_q == IdBits'(Cap - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					req_q <= req; status_q <= ST_OK; st_q <= S_POS;
				end
				S_POS: st_q <= S_DEC;
				S_DEC: begin
					cid_q <= req_q.event_id; ct_q <= req_q.fire_time;
					case (req_q.mode)
						MODE_ADD: begin
							if (pos_rd != '0) begin
								status_q <= ST_PRESENT; st_q <= S_TOP;
							end else if (cnt_q >= PB'(Cap)) begin
								status_q <= ST_FULL; st_q <= S_TOP;
							end else begin
								cnt_q <= cnt_q + PB'(1);
								cur_q <= cnt_q + PB'(1); st_q <= S_RMW;
							end
						end
						MODE_CHANGE: begin
							if (!pos_ok) begin
								status_q <= ST_ABSENT; st_q <= S_TOP;
							end else begin
								cur_q <= pos_rd; st_q <= S_RMW;
							end
						end
						MODE_REMOVE: begin
							if (!pos_ok) begin
								status_q <= ST_ABSENT; st_q <= S_TOP;
							end else begin
								pos_q <= pos_rd; st_q <= S_RLAST;
							end
						end
						default: st_q <= S_TOP;
					endcase
				end
				S_RLAST: st_q <= S_RMW2;
				S_RMW2: begin
					// last entry moves into the vacated slot
					cnt_q <= cnt_q - PB'(1);
					cid_q <= rd_id; ct_q <= rd_t; cur_q <= pos_q;
					st_q <= (pos_q == cnt_q) ? S_TOP : S_RMW;
				end
				S_RMW: st_q <= S_SIFT;
				S_SIFT: begin
					if (cur_q > PB'(1)) st_q <= S_RUP;
					else if (has_left) st_q <= S_RL;
					else st_q <= S_TOP;
				end
				S_RUP: st_q <= S_CMPUP;
				S_CMPUP: begin
					if (ct_q < rd_t) begin
						oth_q <= up_w; oid_q <= rd_id; ot_q <= rd_t; st_q <= S_SW2;
					end else if (has_left) st_q <= S_RL;
					else st_q <= S_TOP;
				end
				S_RL: begin
					second_q <= 1'b0;
					st_q <= has_right ? S_RR : S_CMPDN;
				end
				S_RR: begin
					lid_q <= rd_id; lt_q <= rd_t; second_q <= 1'b1; st_q <= S_CMPDN;
				end
				S_CMPDN: begin
					// pick the earlier child, left on a tie
					if (second_q && !(rd_t < lt_q)) begin
						if (lt_q < ct_q) begin
							oth_q <= left_w; oid_q <= lid_q; ot_q <= lt_q; st_q <= S_SW2;
						end else st_q <= S_TOP;
					end else if (!second_q) begin
						if (rd_t < ct_q) begin
							oth_q <= left_w; oid_q <= rd_id; ot_q <= rd_t; st_q <= S_SW2;
						end else st_q <= S_TOP;
					end else begin
						if (rd_t < ct_q) begin
							oth_q <= right_w; oid_q <= rd_id; ot_q <= rd_t; st_q <= S_SW2;
						end else st_q <= S_TOP;
					end
				end
				S_SW2: st_q <= S_SWP;
				S_SWP: begin
					cur_q <= oth_q; st_q <= S_SIFT;
				end
				S_TOP: st_q <= S_TOPW;
				S_TOPW: st_q <= S_OUT;
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result, registered from the top slot read
	logic [IdBits+TimeBits-1:0] top_q;
	always_ff @(posedge clk) begin
		if (st_q == S_TOPW) top_q <= slot_rd;
	end

	always_comb begin
		busy = (st_q != S_IDLE);
		done = (st_q == S_OUT);
		rsp.status = status_q;
		rsp.is_empty = (cnt_q == '0);
		rsp.entry_count = cnt_q;
		rsp.earliest_id = rsp.is_empty ? '0 : top_q[IdBits+TimeBits-1:TimeBits];
		rsp.earliest_time = rsp.is_empty ? '0 : top_q[TimeBits-1:0];
	end
endmodule
`default_nettype wire
